/* design/mspq_pkg.sv */
// Shared types, constants and control structs for the min-scan priority queue.
package mspq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int DIST_W   = 32;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_READ    = 2'd2,
    REQ_MEMBER  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // request transfer this cycle
    logic run;     // issue reads over the current window
    logic scan;    // compare returning entries
    logic shift;   // write returning entries one place down
    logic finish;  // load result and set up the compaction window
    logic shrink;  // drop one entry from the count
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_scan;
    logic run_done;
    logic is_member;
  } stat_t;

endpackage

/* design/mspq_ctrl.sv */
// Controller state machine for the min-scan priority queue.
module mspq_ctrl
  import mspq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = stat_i.go_scan ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (stat_i.run_done) begin
          state_d = stat_i.is_member ? S_RESP : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat_i.run_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      S_SCAN: begin
        cmd_o.run    = 1'b1;
        cmd_o.scan   = 1'b1;
        cmd_o.finish = stat_i.run_done;
      end
      S_SHIFT: begin
        cmd_o.run    = 1'b1;
        cmd_o.shift  = 1'b1;
        cmd_o.shrink = stat_i.run_done;
      end
      S_RESP: done_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

endmodule

/* design/mspq_dp.sv */
// Datapath: entry memory, count, scan window, minimum tracking and result registers.
module mspq_dp
  import mspq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [1:0]        req_type_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [DIST_W-1:0] in_dist_i,
  output stat_t             stat_o,
  output logic [1:0]        status_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [DIST_W-1:0] out_dist_o,
  output logic              found_o
);

  entry_t mem [CAPACITY];

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic [CNT_W-1:0]  lim_q, lim_d;
  logic              rv_q, rv_d;
  req_e              req_q;
  logic [KEY_W-1:0]  key_q;
  logic [ADDR_W-1:0] rpos_q;
  entry_t            rd_q;
  entry_t            best_q;
  logic [ADDR_W-1:0] best_pos_q;
  logic              found_q;

  logic [1:0]        res_status_q;
  logic [KEY_W-1:0]  res_key_q;
  logic [DIST_W-1:0] res_dist_q;
  logic              res_found_q;

  req_e              req_in;
  logic              full;
  logic              empty;
  logic              issue;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              take_min;

  assign req_in = req_e'(req_type_i);
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign issue  = cmd_i.run && (iss_q < lim_q);

  assign stat_o.go_scan   = (req_in != REQ_INSERT) && !empty;
  assign stat_o.run_done  = (iss_q == lim_q) && !rv_q;
  assign stat_o.is_member = (req_q == REQ_MEMBER);

  // Insert appends at the count; compaction writes each returning entry one place down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[ADDR_W-1:0];
    wr_data = '{key: in_key_i, distance: in_dist_i};
    if (cmd_i.accept && (req_in == REQ_INSERT) && !full) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift && rv_q) begin
      wr_en   = 1'b1;
      wr_addr = rpos_q - ADDR_W'(1);
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[iss_q[ADDR_W-1:0]];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    iss_d = iss_q;
    lim_d = lim_q;
    rv_d  = issue;
    if (cmd_i.accept) begin
      if ((req_in == REQ_INSERT) && !full) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      iss_d = '0;
      lim_d = (req_in == REQ_READ) ? CNT_W'(1) : cnt_q;
    end else if (cmd_i.finish) begin
      // compact everything after the chosen entry
      iss_d = CNT_W'(best_pos_q) + CNT_W'(1);
      lim_d = cnt_q;
    end else if (issue) begin
      iss_d = iss_q + CNT_W'(1);
    end
    if (cmd_i.shrink) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      iss_q <= '0;
      lim_q <= '0;
      rv_q  <= 1'b0;
      req_q <= REQ_INSERT;
    end else begin
      cnt_q <= cnt_d;
      iss_q <= iss_d;
      lim_q <= lim_d;
      rv_q  <= rv_d;
      if (cmd_i.accept) begin
        req_q <= req_in;
      end
    end
  end

  // First entry always taken; strict less-than keeps the earliest on a tie
  assign take_min = (rpos_q == '0) || (rd_q.distance < best_q.distance);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rpos_q <= iss_q[ADDR_W-1:0];
    end
    if (cmd_i.accept) begin
      key_q   <= in_key_i;
      found_q <= 1'b0;
    end else if (cmd_i.scan && rv_q) begin
      if (take_min) begin
        best_q     <= rd_q;
        best_pos_q <= rpos_q;
      end
      if (rd_q.key == key_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      res_key_q   <= '0;
      res_dist_q  <= '0;
      res_found_q <= 1'b0;
      if ((req_in == REQ_INSERT) && full) begin
        res_status_q <= ST_FULL;
      end else if ((req_in != REQ_INSERT) && empty) begin
        res_status_q <= ST_EMPTY;
      end else begin
        res_status_q <= ST_OK;
      end
    end else if (cmd_i.finish) begin
      if (req_q == REQ_MEMBER) begin
        res_found_q <= found_q;
      end else begin
        res_key_q  <= best_q.key;
        res_dist_q <= best_q.distance;
      end
    end
  end

  assign status_o   = res_status_q;
  assign out_key_o  = res_key_q;
  assign out_dist_o = res_dist_q;
  assign found_o    = res_found_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= lim_q)
    else $error("read pointer ran past window end");

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && rv_q) |-> (rpos_q != '0))
    else $error("compaction write below entry zero");

endmodule

/* design/min_scan_priority_queue.sv */
// Top level of the min-scan priority queue: controller and datapath.
// Insert and any empty/full request: result transferred in the cycle after the start transfer.
// Membership scans all n entries; read-oldest and extract-min scan, then move the entries
// after the chosen one one place down; each scan and compaction runs at one memory read a cycle.
// One request at a time; busy stays high until the strobe; the receiver cannot stall.
// Reset clears the entry count and the controller; the entry memory is not cleared.
module min_scan_priority_queue
  import mspq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type_i,
  input  logic [KEY_W-1:0]  in_key_i,
  input  logic [DIST_W-1:0] in_dist_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [DIST_W-1:0] out_dist_o,
  output logic              found_o
);

  cmd_t  cmd;
  stat_t stat;

  mspq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  mspq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_type_i (req_type_i),
    .in_key_i   (in_key_i),
    .in_dist_i  (in_dist_i),
    .stat_o     (stat),
    .status_o   (status_o),
    .out_key_o  (out_key_o),
    .out_dist_o (out_dist_o),
    .found_o    (found_o)
  );

endmodule
